FILE: rtl/assert_macros.svh
// assertion macros for the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define VTP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define VTP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/vtp_pkg.sv
// types and constants for the vertex transform pipeline
package vtp_pkg;
	localparam int WORD_BITS = 32;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_XFORM = 1'b1;

	typedef struct packed {
		logic                        opcode;
		logic [3:0]                  entry_index;
		logic signed [WORD_BITS-1:0] coefficient;
		logic signed [WORD_BITS-1:0] point_x;
		logic signed [WORD_BITS-1:0] point_y;
		logic signed [WORD_BITS-1:0] point_z;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] out_x;
		logic signed [WORD_BITS-1:0] out_y;
		logic signed [WORD_BITS-1:0] out_z;
		logic                        w_zero;
		logic                        saturated;
	} out_item_t;

	// per-item control that rides alongside the divider stages
	typedef struct packed {
		logic       valid;
		logic       wz;
		logic [2:0] neg;
		logic [2:0] big;
	} side_t;
endpackage

FILE: rtl/vtp_mac.sv
// point times matrix: products in stage 1, column sums in stage 2
module vtp_mac #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 xform_valid,
	input  logic signed [vtp_pkg::WORD_BITS-1:0] point_x,
	input  logic signed [vtp_pkg::WORD_BITS-1:0] point_y,
	input  logic signed [vtp_pkg::WORD_BITS-1:0] point_z,
	input  logic signed [vtp_pkg::WORD_BITS-1:0] mtx [16],
	output logic                                 valid_s2,
	output logic signed [2*vtp_pkg::WORD_BITS-FRAC_BITS+1:0] acc_s2 [4]
);
	localparam int W  = vtp_pkg::WORD_BITS;
	localparam int PW = 2*W - FRAC_BITS;
	localparam int AW = PW + 2;

	logic signed [W-1:0]   pt [3];
	logic signed [2*W-1:0] full [3][4];
	logic signed [PW-1:0]  prod_s1 [3][4];
	logic signed [W-1:0]   trans_s1 [4];
	logic                  valid_s1;

	always_comb begin
		pt[0] = point_x;
		pt[1] = point_y;
		pt[2] = point_z;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 4; c++) begin
				full[r][c] = pt[r] * mtx[r*4+c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= xform_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 4; c++) begin
					prod_s1[r][c] <= full[r][c][2*W-1:FRAC_BITS];
				end
			end
			for (int c = 0; c < 4; c++) begin
				trans_s1[c] <= mtx[12+c];
				acc_s2[c]   <= AW'(prod_s1[0][c]) + AW'(prod_s1[1][c])
					+ AW'(prod_s1[2][c]) + AW'(trans_s1[c]);
			end
		end
	end
endmodule

FILE: rtl/vtp_div.sv
// unsigned restoring divider, one quotient bit per pipeline stage
module vtp_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                        clk,
	input  logic                                        en,
	input  logic [3*vtp_pkg::WORD_BITS-FRAC_BITS+1:0]   num,
	input  logic [2*vtp_pkg::WORD_BITS-FRAC_BITS+1:0]   den,
	output logic [vtp_pkg::WORD_BITS-1:0]               quo
);
	localparam int W  = vtp_pkg::WORD_BITS;
	localparam int AW = 2*W - FRAC_BITS + 2;
	localparam int CW = AW + W;

	logic [CW-1:0] rem_s [W];
	logic [AW-1:0] den_s [W];
	logic [W-1:0]  quo_s [W];
	logic [CW-1:0] rem_p [W];
	logic [AW-1:0] den_p [W];
	logic [W-1:0]  quo_p [W];
	logic [CW-1:0] sub_c [W];
	logic          take  [W];

	always_comb begin
		for (int k = 0; k < W; k++) begin
			rem_p[k] = (k == 0) ? num : rem_s[(k == 0) ? 0 : k-1];
			den_p[k] = (k == 0) ? den : den_s[(k == 0) ? 0 : k-1];
			quo_p[k] = (k == 0) ? '0  : quo_s[(k == 0) ? 0 : k-1];
			sub_c[k] = {{W{1'b0}}, den_p[k]} << (W-1-k);
			take[k]  = rem_p[k] >= sub_c[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < W; k++) begin
				rem_s[k] <= take[k] ? rem_p[k] - sub_c[k] : rem_p[k];
				den_s[k] <= den_p[k];
				quo_s[k] <= {quo_p[k][W-2:0], take[k]};
			end
		end
	end

	assign quo = quo_s[W-1];
endmodule

FILE: rtl/vertex_transform_perspective.sv
// top level: matrix store, divide setup, divider lanes and output register
//
// Input channel in_valid/in_ready/in_item carries two kinds of item. A load
// item (opcode OP_LOAD) writes one Q16.16 matrix coefficient and gives no
// result. A transform item (OP_XFORM) multiplies point (x, y, z, 1) by the
// matrix as a row vector and returns (a/w, b/w, c/w) on out_valid/out_ready.
// A transform reads the matrix as left by every item accepted before it.
// An item accepted on the input passes two multiply/add stages, one divide
// setup stage, one divider stage per quotient bit and the output register
// before out_valid. One item is accepted every cycle while the receiver
// takes results.
// Reset clears the matrix to zero and empties the pipeline.
// When the output register holds an item that is not taken, the whole
// pipeline holds and in_ready drops; nothing is lost or repeated.
// A zero w gives zero outputs with w_zero set; quotients that overflow clip.
`include "assert_macros.svh"
module vertex_transform_perspective #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  vtp_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output vtp_pkg::out_item_t out_item
);
	localparam int W  = vtp_pkg::WORD_BITS;
	localparam int AW = 2*W - FRAC_BITS + 2;
	localparam int CW = AW + W;

	logic                  en;
	logic signed [W-1:0]   mtx_q [16];
	logic                  valid_s2;
	logic signed [AW-1:0]  acc_s2 [4];
	logic [AW-1:0]         mag [4];
	logic [CW-1:0]         num_c [3];
	logic [2:0]            big_c;
	logic [2:0]            neg_c;
	logic [CW-1:0]         num_s3 [3];
	logic [AW-1:0]         den_s3;
	vtp_pkg::side_t        side_s3;
	vtp_pkg::side_t        side_sd [W];
	logic [W-1:0]          quo [3];
	logic signed [W-1:0]   res [3];
	logic [2:0]            sat;
	logic                  out_valid_q;
	vtp_pkg::out_item_t    out_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				mtx_q[i] <= '0;
			end
		end else if (in_valid && in_ready && in_item.opcode == vtp_pkg::OP_LOAD) begin
			mtx_q[in_item.entry_index] <= in_item.coefficient;
		end
	end

	vtp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.xform_valid(in_valid && in_ready && in_item.opcode == vtp_pkg::OP_XFORM),
		.point_x    (in_item.point_x),
		.point_y    (in_item.point_y),
		.point_z    (in_item.point_z),
		.mtx        (mtx_q),
		.valid_s2   (valid_s2),
		.acc_s2     (acc_s2)
	);

	// magnitudes, signs and quotient overflow check
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			mag[l] = acc_s2[l][AW-1] ? AW'(-acc_s2[l]) : AW'(acc_s2[l]);
		end
		for (int l = 0; l < 3; l++) begin
			num_c[l] = {{(W-FRAC_BITS){1'b0}}, mag[l], {FRAC_BITS{1'b0}}};
			neg_c[l] = acc_s2[l][AW-1] ^ acc_s2[3][AW-1];
			big_c[l] = num_c[l] >= {mag[3], {W{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
			for (int k = 0; k < W; k++) begin
				side_sd[k] <= '0;
			end
		end else if (en) begin
			side_s3.valid <= valid_s2;
			side_s3.wz    <= acc_s2[3] == '0;
			side_s3.neg   <= neg_c;
			side_s3.big   <= big_c;
			side_sd[0]    <= side_s3;
			for (int k = 1; k < W; k++) begin
				side_sd[k] <= side_sd[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				num_s3[l] <= num_c[l];
			end
			den_s3 <= mag[3];
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		vtp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
			.clk(clk),
			.en (en),
			.num(num_s3[l]),
			.den(den_s3),
			.quo(quo[l])
		);
	end

	// sign, clip and zero-w handling
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (side_sd[W-1].neg[l]) begin
				sat[l] = side_sd[W-1].big[l] || (quo[l][W-1] && |quo[l][W-2:0]);
				res[l] = sat[l] ? {1'b1, {(W-1){1'b0}}} : -quo[l];
			end else begin
				sat[l] = side_sd[W-1].big[l] || quo[l][W-1];
				res[l] = sat[l] ? {1'b0, {(W-1){1'b1}}} : quo[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= side_sd[W-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_sd[W-1].wz) begin
				out_q <= '{out_x: '0, out_y: '0, out_z: '0, w_zero: 1'b1, saturated: 1'b0};
			end else begin
				out_q <= '{out_x: res[0], out_y: res[1], out_z: res[2], w_zero: 1'b0,
					saturated: |sat};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`VTP_ASSERT_NXT(a_load_write, in_valid && in_ready && in_item.opcode == vtp_pkg::OP_LOAD, mtx_q[$past(in_item.entry_index)] == $past(in_item.coefficient), "load item not written to matrix")
	`VTP_ASSERT_IMP(a_wz_den, side_s3.valid, side_s3.wz == (den_s3 == '0), "w zero flag disagrees with divisor")
	`VTP_ASSERT_IMP(a_wz_out, out_valid && out_item.w_zero, out_item.out_x == '0 && out_item.out_y == '0 && out_item.out_z == '0 && !out_item.saturated, "zero w item has nonzero fields")
endmodule

FILE: verif/vertex_transform_perspective_test.sv
// self-checking testbench for the vertex transform with perspective divide
`timescale 1ns / 100ps
module vertex_transform_perspective_test;
	localparam int FRAC = 16;
	localparam int WB = vtp_pkg::WORD_BITS;
	localparam int LATENCY = WB + 4;
	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	vtp_pkg::in_item_t in_item;
	logic out_valid;
	logic out_ready;
	vtp_pkg::out_item_t out_item;

	logic signed [WB-1:0] coef_shadow [16];
	vtp_pkg::out_item_t vertex_queue [$];
	int errors;
	int idle_cycles;
	int sender_gap_max;
	bit hold_off;
	bit drain_done;

	vertex_transform_perspective #(.FRAC_BITS(FRAC)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// exact fixed point quotient with truncation toward zero and clipping
	function automatic logic signed [WB-1:0] quotient(input logic signed [127:0] num,
			input logic signed [127:0] den, inout logic sat);
		logic [127:0] n;
		logic [127:0] d;
		logic [255:0] q;
		logic neg;
		neg = num[127] ^ den[127];
		n = num[127] ? -num : num;
		d = den[127] ? -den : den;
		q = ({128'd0, n} << FRAC) / {128'd0, d};
		if (neg) begin
			if (q > (256'd1 << (WB - 1))) begin
				sat = 1'b1;
				q = 256'd1 << (WB - 1);
			end
			return -q[WB-1:0];
		end
		if (q > (256'd1 << (WB - 1)) - 1) begin
			sat = 1'b1;
			q = (256'd1 << (WB - 1)) - 1;
		end
		return q[WB-1:0];
	endfunction

	function automatic vtp_pkg::out_item_t project_vertex(input vtp_pkg::in_item_t it);
		logic signed [127:0] acc [4];
		logic signed [127:0] prod;
		logic signed [WB-1:0] pt [3];
		vtp_pkg::out_item_t r;
		logic sat;
		pt[0] = it.point_x;
		pt[1] = it.point_y;
		pt[2] = it.point_z;
		for (int c = 0; c < 4; c++) begin
			acc[c] = 128'(coef_shadow[12 + c]);
			for (int k = 0; k < 3; k++) begin
				prod = 128'(pt[k]) * 128'(coef_shadow[k * 4 + c]);
				acc[c] = acc[c] + (prod >>> FRAC);
			end
		end
		r = '0;
		sat = 1'b0;
		if (acc[3] == 0) begin
			r.w_zero = 1'b1;
			return r;
		end
		r.out_x = quotient(acc[0], acc[3], sat);
		r.out_y = quotient(acc[1], acc[3], sat);
		r.out_z = quotient(acc[2], acc[3], sat);
		r.saturated = sat;
		return r;
	endfunction

	task automatic send_item(input vtp_pkg::in_item_t it);
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		if (it.opcode == vtp_pkg::OP_LOAD)
			coef_shadow[it.entry_index] = it.coefficient;
		else
			vertex_queue.push_back(project_vertex(it));
		@(negedge clk);
		if ($urandom_range(0, 3) == 0 && sender_gap_max > 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, sender_gap_max)) @(negedge clk);
		end
	endtask

	function automatic logic signed [WB-1:0] rand_word(input int mode);
		case (mode)
			0: return {1'b0, {(WB-1){1'b1}}};
			1: return {1'b1, {(WB-1){1'b0}}};
			2: return $signed($urandom_range(0, 8)) <<< FRAC;
			3: return -($signed($urandom_range(0, 8)) <<< FRAC);
			4: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
			default: return $urandom;
		endcase
	endfunction

	function automatic vtp_pkg::in_item_t load_item(input int idx,
			input logic signed [WB-1:0] v);
		vtp_pkg::in_item_t it;
		it = '0;
		it.opcode = vtp_pkg::OP_LOAD;
		it.entry_index = 4'(idx);
		it.coefficient = v;
		it.point_x = $urandom;
		it.point_y = $urandom;
		it.point_z = $urandom;
		return it;
	endfunction

	function automatic vtp_pkg::in_item_t xform_item(input logic signed [WB-1:0] x,
			input logic signed [WB-1:0] y, input logic signed [WB-1:0] z);
		vtp_pkg::in_item_t it;
		it.opcode = vtp_pkg::OP_XFORM;
		it.entry_index = 4'($urandom);
		it.coefficient = $urandom;
		it.point_x = x;
		it.point_y = y;
		it.point_z = z;
		return it;
	endfunction

	task automatic test_directed;
		logic signed [WB-1:0] one;
		one = 1 <<< FRAC;
		// zero matrix gives zero w
		send_item(xform_item(32'sh10000, -32'sh20000, 32'sh7fffffff));
		// identity with w = 1
		for (int i = 0; i < 4; i++)
			send_item(load_item(i * 5, one));
		send_item(xform_item(32'sh7fffffff, 32'sh80000000, 32'sh0));
		send_item(xform_item(-32'sh18000, 32'sh1, -32'sh1));
		// small w forces clipping both ways
		send_item(load_item(15, 32'sh1));
		send_item(xform_item(32'sh7fffffff, 32'sh80000000, 32'sh10000));
		// negative w
		send_item(load_item(15, -(2 <<< FRAC)));
		send_item(xform_item(32'sh30000, -32'sh50000, 32'sh7));
		// w from z only, largest coefficients
		send_item(load_item(15, 32'sh0));
		send_item(load_item(11, 32'sh80000000));
		send_item(load_item(0, 32'sh7fffffff));
		send_item(xform_item(32'sh80000000, 32'sh7fffffff, 32'sh80000000));
		send_item(xform_item(32'sh1234, 32'sh0, 32'sh0));
		send_item(xform_item(32'sh1234, 32'sh0, 32'sh0));
	endtask

	task automatic test_random(input int count);
		int mode;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 5) == 0) begin
				mode = $urandom_range(0, 9);
				send_item(load_item($urandom_range(0, 15), rand_word(mode < 6 ? mode : 2)));
			end else begin
				mode = $urandom_range(0, 9);
				if (mode < 6)
					send_item(xform_item(rand_word(4), rand_word(4), rand_word(4)));
				else
					send_item(xform_item(rand_word($urandom_range(0, 5)),
						rand_word($urandom_range(0, 5)), rand_word($urandom_range(0, 5))));
			end
		end
	endtask

	task automatic test_backpressure;
		hold_off = 1'b1;
		fork
			begin
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end
			test_random(120);
		join
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		if (!arst_n || hold_off)
			out_ready <= 1'b0;
		else if (drain_done)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 2) != 0);
	end

	always @(posedge clk) begin
		vtp_pkg::out_item_t exp_item;
		if (arst_n && out_valid && out_ready) begin
			if (vertex_queue.size() == 0) begin
				$display("%0t: unexpected item %h", $time, out_item);
				errors++;
			end else begin
				exp_item = vertex_queue.pop_front();
				if (out_item.out_x !== exp_item.out_x)
					$display("%0t: out_x expected %h got %h", $time, exp_item.out_x, out_item.out_x);
				if (out_item.out_y !== exp_item.out_y)
					$display("%0t: out_y expected %h got %h", $time, exp_item.out_y, out_item.out_y);
				if (out_item.out_z !== exp_item.out_z)
					$display("%0t: out_z expected %h got %h", $time, exp_item.out_z, out_item.out_z);
				if (out_item.w_zero !== exp_item.w_zero)
					$display("%0t: w_zero expected %b got %b", $time, exp_item.w_zero,
						out_item.w_zero);
				if (out_item.saturated !== exp_item.saturated)
					$display("%0t: saturated expected %b got %b", $time, exp_item.saturated,
						out_item.saturated);
				if (out_item !== exp_item)
					errors++;
			end
		end
	end

	// watchdog on cycles with no accepted item
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[vertex_transform_perspective] ERROR");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		hold_off = 1'b0;
		drain_done = 1'b0;
		sender_gap_max = 4;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		for (int i = 0; i < 16; i++)
			coef_shadow[i] = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(500);
		test_backpressure();
		sender_gap_max = 0;
		test_random(300);
		sender_gap_max = 6;
		test_random(380);
		in_valid <= 1'b0;
		drain_done = 1'b1;
		while (vertex_queue.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("[vertex_transform_perspective] OK");
		else
			$display("[vertex_transform_perspective] ERROR");
		$finish;
	end
endmodule
